@@ hdl/jos_pkg.sv @@
package jos_pkg;

    localparam int MAX_MEMBERS = 32;
    localparam int MEMBER_CAP  = (MAX_MEMBERS < 32) ? MAX_MEMBERS : 32;
    localparam int STEP_W      = 8;
    localparam int COUNT_W     = 6;
    localparam int INDEX_W     = 5;
    localparam int MASK_W      = 32;
    localparam int BIT_W       = 3;
    localparam logic [STEP_W-1:0] STEP_RESET = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic walk_step;
        logic remove;
    } t_cmd;

    typedef struct packed {
        logic in_zero;
        logic mod_last;
        logic walk_done;
        logic rem_one;
    } t_status;

endpackage

@@ hdl/jos_ctrl.sv @@
module jos_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  jos_pkg::t_status i_status,
    output jos_pkg::t_cmd   o_cmd,
    output logic            busy,
    output logic            o_strobe
);
    import jos_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && !i_status.in_zero) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (i_status.mod_last) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_status.walk_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.rem_one) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_MOD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        busy     = 1'b1;
        o_strobe = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            ST_WALK: begin
                o_cmd.walk_step = !i_status.walk_done;
            end
            ST_EMIT: begin
                o_strobe     = 1'b1;
                o_cmd.remove = !i_status.rem_one;
            end
            default: busy = 1'b1;
        endcase
    end

endmodule

@@ hdl/jos_dp.sv @@
module jos_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jos_pkg::STEP_W-1:0]    i_cfg_wdata,
    input  logic [jos_pkg::COUNT_W-1:0]   i_member_count,
    input  jos_pkg::t_cmd                 i_cmd,
    output jos_pkg::t_status              o_status,
    output logic [jos_pkg::INDEX_W-1:0]   o_member_index,
    output logic                          o_is_survivor,
    output logic                          o_last
);
    import jos_pkg::*;

    logic [STEP_W-1:0]  r_step_k;
    logic [MASK_W-1:0]  r_mask;
    logic [INDEX_W-1:0] r_pos;
    logic [COUNT_W-1:0] r_n;
    logic [COUNT_W-1:0] r_remaining;
    logic               r_dead;
    logic [COUNT_W-1:0] r_div;
    logic [BIT_W-1:0]   r_bit;
    logic [COUNT_W-1:0] r_walk;

    logic [COUNT_W-1:0] n_sat;
    logic [MASK_W-1:0]  load_mask;
    logic [STEP_W-1:0]  dividend;
    logic [COUNT_W-1:0] shifted;
    logic [COUNT_W-1:0] div_next;
    logic [INDEX_W-1:0] pos_next;

    always_comb begin
        n_sat = (i_member_count > COUNT_W'(MEMBER_CAP)) ? COUNT_W'(MEMBER_CAP)
                                                         : i_member_count;
        if (n_sat >= COUNT_W'(MASK_W)) begin
            load_mask = '1;
        end else begin
            load_mask = (MASK_W'(1) << n_sat) - MASK_W'(1);
        end
        dividend = (r_step_k == '0) ? '0 : r_step_k - STEP_W'(1);
        shifted  = {r_div[COUNT_W-2:0], dividend[r_bit]};
        div_next = (shifted >= r_remaining) ? shifted - r_remaining : shifted;
        pos_next = ({1'b0, r_pos} == r_n - COUNT_W'(1)) ? '0 : r_pos + INDEX_W'(1);
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_k <= STEP_RESET;
        end else if (i_cfg_we) begin
            r_step_k <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_pos       <= '0;
            r_n         <= '0;
            r_remaining <= '0;
            r_dead      <= 1'b0;
            r_div       <= '0;
            r_bit       <= '1;
            r_walk      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_mask      <= load_mask;
                r_pos       <= '0;
                r_n         <= n_sat;
                r_remaining <= n_sat;
                r_dead      <= 1'b0;
                r_div       <= '0;
                r_bit       <= '1;
            end
            // bit-serial remainder of (k - 1) by living count
            if (i_cmd.mod_step) begin
                r_div <= div_next;
                r_bit <= r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    r_walk <= div_next + COUNT_W'(r_dead);
                end
            end
            if (i_cmd.walk_step) begin
                r_pos <= pos_next;
                if (r_mask[pos_next]) begin
                    r_walk <= r_walk - COUNT_W'(1);
                end
            end
            if (i_cmd.remove) begin
                r_mask[r_pos] <= 1'b0;
                r_remaining   <= r_remaining - COUNT_W'(1);
                r_dead        <= 1'b1;
                r_div         <= '0;
                r_bit         <= '1;
            end
        end
    end

    always_comb begin
        o_status.in_zero   = (i_member_count == '0);
        o_status.mod_last  = (r_bit == '0);
        o_status.walk_done = (r_walk == '0);
        o_status.rem_one   = (r_remaining == COUNT_W'(1));
        o_member_index     = r_pos;
        o_is_survivor      = (r_remaining == COUNT_W'(1));
        o_last             = (r_remaining == COUNT_W'(1));
    end

endmodule

@@ hdl/josephus_elimination_order_unit.sv @@
// Josephus elimination order. Pulse start while busy is low with i_member_count
// (1 to 32, larger values saturate to 32, zero gives no results) and the unit
// emits one transaction per member on o_strobe: eliminated members in order, then
// the survivor with o_is_survivor and o_last set. Each transaction is on the ports
// for one cycle only and the receiver cannot stall it. Each elimination runs a
// bit-serial remainder of (k - 1) by the living count, walks the ring position
// by position, and then emits its output transaction. i_cfg_we writes step_k
// (reset 3, zero acts as one) and may only be used while busy is low.
module josephus_elimination_order_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cfg_we,
    input  logic [jos_pkg::STEP_W-1:0]  i_cfg_wdata,
    input  logic [jos_pkg::COUNT_W-1:0] i_member_count,
    output logic                        o_strobe,
    output logic [jos_pkg::INDEX_W-1:0] o_member_index,
    output logic                        o_is_survivor,
    output logic                        o_last
);
    import jos_pkg::*;

    t_cmd    cmd;
    t_status status;

    jos_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    jos_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_member_count (i_member_count),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_member_index (o_member_index),
        .o_is_survivor  (o_is_survivor),
        .o_last         (o_last)
    );

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jos_pkg::*;

    localparam int DRAIN_CYCLES = 1400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_ROWS     = 25;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 20;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic               surv;
        logic               fin;
    } t_pick;

    // wr rows load step_k, the rest issue one member count
    typedef struct packed {
        logic               wr;
        logic [STEP_W-1:0]  val;
        logic [COUNT_W-1:0] cnt;
        logic               typed;
        logic [INDEX_W-1:0] surv;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic [STEP_W-1:0]  i_cfg_wdata;
    logic [COUNT_W-1:0] i_member_count;
    logic               o_strobe;
    logic [INDEX_W-1:0] o_member_index;
    logic               o_is_survivor;
    logic               o_last;

    t_pick              pending_picks[$];
    logic [STEP_W-1:0]  step_reg;
    logic [MASK_W-1:0]  ring_alive;
    int                 ring_pos;
    int                 ring_left;
    int                 miss_count = 0;
    int                 cycle_count = 0;
    bit                 idling_on;

    t_row script [0:NUM_ROWS-1] = '{
        '{1'b0, 8'd0,   6'd7,  1'b1, 5'd3},
        '{1'b0, 8'd0,   6'd1,  1'b1, 5'd0},
        '{1'b0, 8'd0,   6'd0,  1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd2,  1'b1, 5'd1},
        '{1'b0, 8'd0,   6'd4,  1'b1, 5'd0},
        '{1'b0, 8'd0,   6'd63, 1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd33, 1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd32, 1'b0, 5'd0},
        '{1'b1, 8'd1,   6'd0,  1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd32, 1'b1, 5'd31},
        '{1'b0, 8'd0,   6'd5,  1'b1, 5'd4},
        '{1'b0, 8'd0,   6'd1,  1'b1, 5'd0},
        '{1'b1, 8'd0,   6'd0,  1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd32, 1'b1, 5'd31},
        '{1'b0, 8'd0,   6'd63, 1'b1, 5'd31},
        '{1'b1, 8'd2,   6'd0,  1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd5,  1'b1, 5'd2},
        '{1'b0, 8'd0,   6'd32, 1'b1, 5'd0},
        '{1'b0, 8'd0,   6'd0,  1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd6,  1'b1, 5'd4},
        '{1'b1, 8'd255, 6'd0,  1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd2,  1'b1, 5'd1},
        '{1'b0, 8'd0,   6'd32, 1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd31, 1'b0, 5'd0},
        '{1'b0, 8'd0,   6'd1,  1'b1, 5'd0}
    };

    josephus_elimination_order_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_member_count (i_member_count),
        .o_strobe       (o_strobe),
        .o_member_index (o_member_index),
        .o_is_survivor  (o_is_survivor),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int next_alive(input int p, input int n);
        int q;
        for (int i = 1; i <= n; i++) begin
            q = (p + i) % n;
            if (ring_alive[q])
                return q;
        end
        return p;
    endfunction

    function automatic void predict_elimination_order(input logic [COUNT_W-1:0] cnt);
        int    n;
        int    k;
        int    moves;
        int    victim;
        t_pick pick;
        n = (cnt > MEMBER_CAP) ? MEMBER_CAP : int'(cnt);
        k = (step_reg == 0) ? 1 : int'(step_reg);
        ring_pos = 0;
        ring_left = n;
        if (n == 0) begin
            ring_alive = '0;
            return;
        end
        ring_alive = (n >= 32) ? '1 : ((MASK_W'(1) << n) - 1);
        while (ring_left > 1) begin
            moves = (k - 1) % ring_left;
            victim = ring_pos;
            for (int m = 0; m < moves; m++)
                victim = next_alive(victim, n);
            ring_pos = next_alive(victim, n);
            ring_alive[victim] = 1'b0;
            ring_left--;
            pick.idx = INDEX_W'(victim);
            pick.surv = 1'b0;
            pick.fin = 1'b0;
            pending_picks.push_back(pick);
        end
        pick.idx = INDEX_W'(ring_pos);
        pick.surv = 1'b1;
        pick.fin = 1'b1;
        pending_picks.push_back(pick);
    endfunction

    task automatic flag_miss(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        miss_count++;
    endtask

    task automatic wait_idle();
        while (pending_picks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        step_reg = v;
    endtask

    // keep_on leaves start high so the next transaction follows back to back
    task automatic send_count(input logic [COUNT_W-1:0] c, input bit keep_on,
                              input bit typed, input logic [INDEX_W-1:0] surv);
        t_pick tail;
        start <= 1'b1;
        i_member_count <= c;
        do @(posedge i_clk); while (busy);
        predict_elimination_order(c);
        if (typed && pending_picks.size() != 0) begin
            tail = pending_picks.pop_back();
            tail.idx = surv;
            pending_picks.push_back(tail);
        end
        if (!keep_on)
            start <= 1'b0;
    endtask

    function automatic int pick_gap();
        if (!idling_on || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(1, 11);
    endfunction

    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_strobe) begin
            if (pending_picks.size() == 0) begin
                flag_miss("unexpected transaction, index", o_member_index, -1);
            end else begin
                want = pending_picks.pop_front();
                if (o_member_index !== want.idx)
                    flag_miss("member_index", o_member_index, want.idx);
                if (o_is_survivor !== want.surv)
                    flag_miss("is_survivor", o_is_survivor, want.surv);
                if (o_last !== want.fin)
                    flag_miss("last", o_last, want.fin);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int               gap;
        bit               more;
        logic [COUNT_W-1:0] c;
        int               sel;
        idling_on = 1'b1;
        step_reg = STEP_RESET;
        ring_alive = '0;
        ring_pos = 0;
        ring_left = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_member_count = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (script[r].wr) begin
                write_step(script[r].val);
            end else begin
                gap = pick_gap();
                more = (r + 1 < NUM_ROWS) && !script[r + 1].wr && gap == 0;
                send_count(script[r].cnt, more, script[r].typed, script[r].surv);
                repeat (gap) @(posedge i_clk);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: write_step(STEP_W'($urandom_range(1, 8)));
                1: write_step(STEP_W'($urandom_range(0, 255)));
                2: write_step(8'd255);
                3: write_step(STEP_W'($urandom_range(9, 64)));
                default: write_step(STEP_W'($urandom_range(0, 255)));
            endcase
            idling_on = (p != NUM_PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                sel = $urandom_range(0, 15);
                if (sel == 0)
                    c = '0;
                else if (sel <= 2)
                    c = COUNT_W'($urandom_range(33, 63));
                else if (sel == 3)
                    c = COUNT_W'(MEMBER_CAP);
                else
                    c = COUNT_W'($urandom_range(1, 32));
                gap = pick_gap();
                more = (i + 1 < PHASE_ITEMS) && gap == 0;
                send_count(c, more, 1'b0, '0);
                repeat (gap) @(posedge i_clk);
            end
        end

        while (pending_picks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (miss_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
